@@ src/assert_macros.svh @@
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ src/mrm_pkg.sv @@
package mrm_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int ROW_WIDTH  = 2;
   localparam int LANES      = 4;
   localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + $clog2(LANES);

   typedef enum logic {
      OP_LOAD     = 1'b0,
      OP_MULTIPLY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } lane_ctl_type;

endpackage

@@ src/mrm_req_if.sv @@
interface mrm_req_if;
   logic                                    valid;
   logic                                    ready;
   mrm_pkg::opcode_type                     opcode;
   logic [mrm_pkg::ROW_WIDTH-1:0]           row_index;
   logic signed [mrm_pkg::ELEM_WIDTH-1:0]   elem_a;
   logic signed [mrm_pkg::ELEM_WIDTH-1:0]   elem_b;
   logic signed [mrm_pkg::ELEM_WIDTH-1:0]   elem_c;
   logic signed [mrm_pkg::ELEM_WIDTH-1:0]   elem_d;

   modport source (
      output valid, opcode, row_index, elem_a, elem_b, elem_c, elem_d,
      input  ready
   );

   modport sink (
      input  valid, opcode, row_index, elem_a, elem_b, elem_c, elem_d,
      output ready
   );
endinterface

@@ src/mrm_rsp_if.sv @@
interface mrm_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [mrm_pkg::ELEM_WIDTH-1:0]   prod_a;
   logic signed [mrm_pkg::ELEM_WIDTH-1:0]   prod_b;
   logic signed [mrm_pkg::ELEM_WIDTH-1:0]   prod_c;
   logic signed [mrm_pkg::ELEM_WIDTH-1:0]   prod_d;

   modport source (
      output valid, prod_a, prod_b, prod_c, prod_d,
      input  ready
   );

   modport sink (
      input  valid, prod_a, prod_b, prod_c, prod_d,
      output ready
   );
endinterface

@@ src/matrix_row_multiply_4x4_top.sv @@
// A multiply request's row goes through the product, sum and merge registers in turn.
// One request per cycle unless the output stalls; the four column lanes multiply in parallel.
// A load request writes the stored row at once; a multiply in the next cycle sees it.
// Reset clears the pipeline valid bits; the stored matrix is not cleared.
`include "assert_macros.svh"

module matrix_row_multiply_4x4_top #(
   parameter int FRACTION_BITS = 16,
   parameter int MATRIX_DIM    = 4
) (
   input  logic       clock,
   input  logic       reset,
   mrm_req_if.sink    req_if,
   mrm_rsp_if.source  rsp_if
);
   import mrm_pkg::*;

   localparam int DIM_EFF = (MATRIX_DIM < LANES) ? MATRIX_DIM : LANES;

   logic signed [ELEM_WIDTH-1:0] store_ff [DIM_EFF][DIM_EFF];
   logic signed [ELEM_WIDTH-1:0] elem     [LANES];
   logic signed [ELEM_WIDTH-1:0] weight   [LANES][LANES];
   logic signed [SUM_WIDTH-1:0]  sum      [LANES];

   logic         prod_valid_ff, prod_valid_in;
   logic         sum_valid_ff, sum_valid_in;
   logic         prod_en, sum_en, merge_ready;
   logic         accept, load_accept;
   lane_ctl_type lane_ctl;

   assign elem[0] = req_if.elem_a;
   assign elem[1] = req_if.elem_b;
   assign elem[2] = req_if.elem_c;
   assign elem[3] = req_if.elem_d;

   assign sum_en       = !sum_valid_ff || merge_ready;
   assign prod_en      = !prod_valid_ff || sum_en;
   assign req_if.ready = prod_en;
   assign accept       = req_if.valid && prod_en;
   assign load_accept  = accept && (req_if.opcode == OP_LOAD);

   assign lane_ctl.prod_en = prod_en;
   assign lane_ctl.sum_en  = sum_en;

   for (genvar r = 0; r < DIM_EFF; r++) begin : g_row
      always_ff @(posedge clock) begin
         if (load_accept && (req_if.row_index == ROW_WIDTH'(r))) begin
            for (int k = 0; k < DIM_EFF; k++) begin
               store_ff[r][k] <= elem[k];
            end
         end
      end
   end

   for (genvar y = 0; y < LANES; y++) begin : g_col
      for (genvar k = 0; k < LANES; k++) begin : g_tap
         if (y < DIM_EFF && k < DIM_EFF) begin : g_used
            assign weight[y][k] = store_ff[k][y];
         end else begin : g_zero
            assign weight[y][k] = '0;
         end
      end

      mrm_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .elem   (elem),
         .weight (weight[y]),
         .sum_ff (sum[y])
      );
   end

   always_comb begin
      prod_valid_in = prod_valid_ff;
      sum_valid_in  = sum_valid_ff;
      if (prod_en) begin
         prod_valid_in = req_if.valid && (req_if.opcode == OP_MULTIPLY);
      end
      if (sum_en) begin
         sum_valid_in = prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   mrm_merge #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sum_valid_ff),
      .in_ready (merge_ready),
      .sum      (sum),
      .rsp_if   (rsp_if)
   );

   `ASSERT_NEXT(a_mul_enters, clock, reset,
      accept && (req_if.opcode == OP_MULTIPLY), prod_valid_ff)
   `ASSERT_NEXT(a_load_no_entry, clock, reset,
      load_accept, !prod_valid_ff)
   `ASSERT_NEXT(a_sum_holds, clock, reset,
      sum_valid_ff && !merge_ready, sum_valid_ff)
   `ASSERT_SAME(a_rsp_from_sum, clock, reset,
      $rose(rsp_if.valid), $past(sum_valid_ff))
endmodule

@@ src/mrm_lane.sv @@
module mrm_lane (
   input  logic                                   clock,
   input  mrm_pkg::lane_ctl_type                  ctl,
   input  logic signed [mrm_pkg::ELEM_WIDTH-1:0]  elem   [mrm_pkg::LANES],
   input  logic signed [mrm_pkg::ELEM_WIDTH-1:0]  weight [mrm_pkg::LANES],
   output logic signed [mrm_pkg::SUM_WIDTH-1:0]   sum_ff
);
   import mrm_pkg::*;

   logic signed [PROD_WIDTH-1:0] prod_in [LANES];
   logic signed [PROD_WIDTH-1:0] prod_ff [LANES];
   logic signed [SUM_WIDTH-1:0]  sum_in;

   for (genvar k = 0; k < LANES; k++) begin : g_mul
      assign prod_in[k] = elem[k] * weight[k];
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < LANES; k++) begin
         sum_in = sum_in + SUM_WIDTH'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end
endmodule

@@ src/mrm_merge.sv @@
module mrm_merge #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [mrm_pkg::SUM_WIDTH-1:0]  sum [mrm_pkg::LANES],
   mrm_rsp_if.source                             rsp_if
);
   import mrm_pkg::*;

   localparam logic signed [ELEM_WIDTH-1:0] SAT_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
   localparam logic signed [ELEM_WIDTH-1:0] SAT_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

   logic                          valid_ff;
   logic                          valid_in;
   logic signed [ELEM_WIDTH-1:0]  prod_in [LANES];
   logic signed [ELEM_WIDTH-1:0]  prod_ff [LANES];

   assign in_ready = !valid_ff || rsp_if.ready;

   for (genvar y = 0; y < LANES; y++) begin : g_sat
      logic signed [SUM_WIDTH-1:0]    shifted;
      logic [SUM_WIDTH-ELEM_WIDTH:0]  upper;

      assign shifted = sum[y] >>> FRACTION_BITS;
      assign upper   = shifted[SUM_WIDTH-1:ELEM_WIDTH-1];

      always_comb begin
         if ((&upper) || !(|upper)) begin
            prod_in[y] = shifted[ELEM_WIDTH-1:0];
         end else if (shifted[SUM_WIDTH-1]) begin
            prod_in[y] = SAT_MIN;
         end else begin
            prod_in[y] = SAT_MAX;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_if.valid  = valid_ff;
   assign rsp_if.prod_a = prod_ff[0];
   assign rsp_if.prod_b = prod_ff[1];
   assign rsp_if.prod_c = prod_ff[2];
   assign rsp_if.prod_d = prod_ff[3];
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import mrm_pkg::*;

   localparam int FRACTION_BITS = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 1080;
   localparam int QUIET_FROM    = 950;
   localparam int DRAIN_AT      = 500;

   typedef logic [LANES-1:0][ELEM_WIDTH-1:0] row_vec_type;

   class product_scoreboard;
      row_vec_type right_rows [LANES];
      row_vec_type expected_rows [$];
      int unsigned failures;

      function int pending();
         return expected_rows.size();
      endfunction

      function logic [ELEM_WIDTH-1:0] dot_saturate(row_vec_type left, int col);
         logic signed [SUM_WIDTH-1:0] acc;
         logic signed [PROD_WIDTH-1:0] term;
         acc = '0;
         for (int k = 0; k < LANES; k++) begin
            term = $signed(left[k]) * $signed(right_rows[k][col]);
            acc = acc + term;
         end
         acc = acc >>> FRACTION_BITS;
         if (acc > $signed({{(SUM_WIDTH-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}}))
            return {1'b0, {(ELEM_WIDTH-1){1'b1}}};
         if (acc < $signed({{(SUM_WIDTH-ELEM_WIDTH+1){1'b1}}, {(ELEM_WIDTH-1){1'b0}}}))
            return {1'b1, {(ELEM_WIDTH-1){1'b0}}};
         return acc[ELEM_WIDTH-1:0];
      endfunction

      function void note_request(opcode_type op, logic [ROW_WIDTH-1:0] row,
                                 row_vec_type elems);
         row_vec_type prod;
         if (op == OP_LOAD) begin
            right_rows[row] = elems;
         end else begin
            for (int y = 0; y < LANES; y++)
               prod[y] = dot_saturate(elems, y);
            expected_rows.push_back(prod);
         end
      endfunction

      function void report(string what, logic [ELEM_WIDTH-1:0] want,
                           logic [ELEM_WIDTH-1:0] got);
         failures++;
         if (failures <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
      endfunction

      function void check_row(row_vec_type got);
         row_vec_type want;
         string       names [LANES];
         names = '{"prod_a", "prod_b", "prod_c", "prod_d"};
         if (expected_rows.size() == 0) begin
            report("unexpected product row", 'x, got[0]);
            return;
         end
         want = expected_rows.pop_front();
         for (int y = 0; y < LANES; y++)
            if (want[y] !== got[y])
               report(names[y], want[y], got[y]);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic quiet = 1'b0;
   int unsigned cycles = 0;

   product_scoreboard sb = new();

   mrm_req_if req_if();
   mrm_rsp_if rsp_if();

   matrix_row_multiply_4x4_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[matrix_row_multiply_4x4_top] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_request(req_if.opcode, req_if.row_index,
                         {req_if.elem_d, req_if.elem_c, req_if.elem_b, req_if.elem_a});
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_row({rsp_if.prod_d, rsp_if.prod_c, rsp_if.prod_b, rsp_if.prod_a});
   end

   initial begin
      bit stalls_on;
      rsp_if.ready <= 1'b0;
      stalls_on = 1'b1;
      forever begin
         if (!quiet && stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if ($urandom_range(0, 15) == 0)
            stalls_on = ~stalls_on;
      end
   end

   task automatic send_request(opcode_type op, logic [ROW_WIDTH-1:0] row,
                               logic [ELEM_WIDTH-1:0] a, logic [ELEM_WIDTH-1:0] b,
                               logic [ELEM_WIDTH-1:0] c, logic [ELEM_WIDTH-1:0] d);
      req_if.valid     <= 1'b1;
      req_if.opcode    <= op;
      req_if.row_index <= row;
      req_if.elem_a    <= a;
      req_if.elem_b    <= b;
      req_if.elem_c    <= c;
      req_if.elem_d    <= d;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic load_uniform(logic [ELEM_WIDTH-1:0] v);
      for (int r = 0; r < LANES; r++)
         send_request(OP_LOAD, r[ROW_WIDTH-1:0], v, v, v, v);
   endtask

   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [ELEM_WIDTH-1:0] pick_elem(int unsigned mode);
      case (mode)
         0:       return $urandom();
         1:       return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
         2:       return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
         default: begin
            case ($urandom_range(0, 6))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               3:       return 32'hFFFF_FFFF;
               4:       return 32'h0001_0000;
               5:       return 32'h0000_0001;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   initial begin
      int unsigned      mode;
      bit               gaps_on;
      opcode_type       op;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.opcode    <= OP_LOAD;
      req_if.row_index <= '0;
      req_if.elem_a    <= '0;
      req_if.elem_b    <= '0;
      req_if.elem_c    <= '0;
      req_if.elem_d    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_LOAD, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
      send_request(OP_LOAD, 2'd1, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
      send_request(OP_LOAD, 2'd2, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
      send_request(OP_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      send_request(OP_MULTIPLY, 2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_MULTIPLY, 2'd0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_8000,
                   32'hFFFE_8000);
      send_request(OP_LOAD, 2'd0, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001, 32'hFFFF_FFFF);
      send_request(OP_MULTIPLY, 2'd1, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
      load_uniform(32'h7FFF_FFFF);
      send_request(OP_MULTIPLY, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF);
      send_request(OP_MULTIPLY, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000);
      load_uniform(32'h8000_0000);
      send_request(OP_MULTIPLY, 2'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000);
      send_request(OP_MULTIPLY, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF);

      gaps_on = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == QUIET_FROM)
            quiet <= 1'b1;
         mode = $urandom_range(0, 9);
         mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 8) ? 2 : 3;
         op = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_MULTIPLY;
         send_request(op, ROW_WIDTH'($urandom_range(0, LANES - 1)),
                      pick_elem(mode), pick_elem(mode), pick_elem(mode), pick_elem(mode));
         if (i == DRAIN_AT) begin
            hold_until_drained();
         end else if (i < QUIET_FROM && gaps_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         if ($urandom_range(0, 49) == 0)
            gaps_on = ~gaps_on;
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (sb.failures == 0)
         $display("[matrix_row_multiply_4x4_top] OK");
      else
         $display("[matrix_row_multiply_4x4_top] ERROR");
      $finish;
   end
endmodule
